// File: rtl/asc_pkg.sv
package asc_pkg;

   // Table and output sizing
   localparam int TABLE_ENTRIES = 32;
   localparam int MAX_SEGMENTS  = 64;
   localparam int MAX_BOUNDS    = 2 * TABLE_ENTRIES + 2;
   localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
   localparam int BOUND_W       = $clog2(MAX_BOUNDS + 1);
   localparam int SEG_W         = $clog2(MAX_SEGMENTS + 1);
   localparam int SCAN_W        = $clog2(2 * TABLE_ENTRIES + 1);
   localparam int ADDR_W        = 128;
   localparam int LEN_W         = 8;

   // Item codes
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;
   localparam logic FAM_V4    = 1'b0;
   localparam logic FAM_V6    = 1'b1;

   typedef enum logic [2:0] {
      ADDR_UNICAST  = 3'd0,
      ADDR_UNSPEC   = 3'd1,
      ADDR_BCAST    = 3'd2,
      ADDR_MCAST    = 3'd3,
      ADDR_LOOPBACK = 3'd4,
      ADDR_MAPPED   = 3'd5
   } addr_class_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERR,
      ST_BINIT,
      ST_BSCAN,
      ST_SSCAN,
      ST_SEND,
      ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_INSERT,
      CELL_ROTATE
   } cell_op_type;

   // Control broadcast to every bound cell
   typedef struct packed {
      cell_op_type        op;
      logic [ADDR_W-1:0]  ins_val;
      logic [ADDR_W-1:0]  head_val;
   } cell_ctl_type;

   // What a cell hands to its right neighbor
   typedef struct packed {
      logic [ADDR_W-1:0]  val;
      logic               valid;
      logic               lt;
   } cell_link_type;

   // One table entry, network and last address precomputed at load
   typedef struct packed {
      logic               family;
      logic               special;
      logic [LEN_W-1:0]   len;
      logic [ADDR_W-1:0]  net;
      logic [ADDR_W-1:0]  last;
   } entry_type;

   function automatic addr_class_type addr_class(input logic fam,
                                                 input logic [ADDR_W-1:0] a);
      addr_class_type r;
      r = ADDR_UNICAST;
      if (fam == FAM_V4) begin
         if (a[31:0] == 32'd0)               r = ADDR_UNSPEC;
         else if (a[31:0] == 32'hFFFF_FFFF)  r = ADDR_BCAST;
         else if (a[31:28] == 4'hE)          r = ADDR_MCAST;
         else if (a[31:24] == 8'h7F)         r = ADDR_LOOPBACK;
      end else begin
         if (a == '0)                        r = ADDR_UNSPEC;
         else if (a == ADDR_W'(1))           r = ADDR_LOOPBACK;
         else if (a[127:120] == 8'hFF)       r = ADDR_MCAST;
         else if (a[127:64] == 64'd0 && a[63:32] == 32'h0000_FFFF) r = ADDR_MAPPED;
      end
      return r;
   endfunction

endpackage

// File: rtl/asc_ram.sv
module asc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/asc_cell.sv
module asc_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  asc_pkg::cell_ctl_type       ctl,
   input  asc_pkg::cell_link_type      left,
   input  logic [asc_pkg::ADDR_W-1:0]  right_val,
   input  logic                        is_tail,
   output asc_pkg::cell_link_type      link,
   output logic                        eq
);

   logic [asc_pkg::ADDR_W-1:0] val_ff, val_in;
   logic                       valid_ff, valid_in;
   logic                       lt;

   // compare against the value being inserted
   always_comb begin
      lt = !valid_ff || (ctl.ins_val < val_ff);
      eq = valid_ff && (ctl.ins_val == val_ff);
   end

   // sorted insert shifts right, rotate shifts left with the head wrapping to the tail
   always_comb begin
      val_in   = val_ff;
      valid_in = valid_ff;
      case (ctl.op)
         asc_pkg::CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         asc_pkg::CELL_INSERT: begin
            if (lt) begin
               if (left.lt) begin
                  val_in   = left.val;
                  valid_in = left.valid;
               end else begin
                  val_in   = ctl.ins_val;
                  valid_in = 1'b1;
               end
            end
         end
         asc_pkg::CELL_ROTATE: begin
            val_in = is_tail ? ctl.head_val : right_val;
         end
         default: begin
            val_in = val_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      val_ff <= val_in;
   end

   assign link = '{val: val_ff, valid: valid_ff, lt: lt};

endmodule

// File: rtl/address_range_segment_classifier.sv
// Address range segment classifier.
// Input channel: an item is taken when start is high and busy is low. A load
// item (req_action 0) writes a prefix entry into table slot req_slot in that
// same cycle and gives no result; busy stays low. A query item (req_action 1)
// gives an interval req_first..req_last of one family and yields one result
// per merged segment on the rsp_ ports, each marked by rsp_valid for exactly
// one cycle; rsp_last marks the final transfer of the query. A bad interval
// gives a single transfer with rsp_error set.
// Flow of a query with n distinct bounds: the bounds are first gathered into
// the sorted cell row, then two passes of n segments follow, each segment one
// sweep of the entry table through its single read port; the first pass counts
// segments so the truncation flag is known, the second sends them. Results
// appear during the second pass.
// Reset clears all entry valid bits and the controller; the receiver has no
// way to stall, so every result is delivered in the cycle it is shown.
module address_range_segment_classifier (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic         req_action,
   input  logic [4:0]   req_slot,
   input  logic         req_family,
   input  logic [63:0]  req_first_hi,
   input  logic [63:0]  req_first_lo,
   input  logic [63:0]  req_last_hi,
   input  logic [63:0]  req_last_lo,
   input  logic [7:0]   req_prefix_len,
   input  logic         req_special_purpose,
   output logic         rsp_valid,
   output logic [63:0]  rsp_seg_first_hi,
   output logic [63:0]  rsp_seg_first_lo,
   output logic [63:0]  rsp_seg_last_hi,
   output logic [63:0]  rsp_seg_last_lo,
   output logic         rsp_special_found,
   output logic [4:0]   rsp_special_slot,
   output logic         rsp_space_found,
   output logic [4:0]   rsp_space_slot,
   output logic [2:0]   rsp_addr_type,
   output logic         rsp_error,
   output logic         rsp_truncated,
   output logic         rsp_last
);

   localparam int AW = asc_pkg::ADDR_W;
   localparam int NB = asc_pkg::MAX_BOUNDS;
   localparam int SW = asc_pkg::SLOT_W;
   localparam int BW = asc_pkg::BOUND_W;
   localparam int GW = asc_pkg::SEG_W;
   localparam int CW = asc_pkg::SCAN_W;
   localparam int LW = asc_pkg::LEN_W;
   localparam int EW = $bits(asc_pkg::entry_type);

   asc_pkg::state_type state_ff, state_in;

   logic [AW-1:0] qf_ff, qf_in, ql_ff, ql_in;
   logic          qfam_ff, qfam_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rv_ff, rv_in, rph_ff, rph_in, rev_ff, rev_in;
   logic [asc_pkg::TABLE_ENTRIES-1:0] ev_ff, ev_in;
   logic [BW-1:0] n_ff, n_in, seg_idx_ff, seg_idx_in, ns_ff, ns_in;
   logic          pass_ff, pass_in;
   logic [GW-1:0] emit_tot_ff, emit_tot_in, emitted_ff, emitted_in;
   logic          trunc_ff, trunc_in;

   // best covering entries of the current segment
   logic          b_sf_ff, b_sf_in, b_af_ff, b_af_in;
   logic [SW-1:0] b_ss_ff, b_ss_in, b_as_ff, b_as_in;
   logic [LW-1:0] b_slen_ff, b_slen_in, b_alen_ff, b_alen_in;

   // pending merged segment
   logic          p_valid_ff, p_valid_in;
   logic [AW-1:0] p_first_ff, p_first_in, p_last_ff, p_last_in;
   logic          p_sf_ff, p_sf_in, p_af_ff, p_af_in;
   logic [SW-1:0] p_ss_ff, p_ss_in, p_as_ff, p_as_in;
   logic [2:0]    p_ty_ff, p_ty_in;

   // result registers
   logic          o_valid_ff, o_valid_in;
   logic [AW-1:0] o_first_ff, o_first_in, o_last_ff, o_last_in;
   logic          o_sf_ff, o_sf_in, o_af_ff, o_af_in;
   logic [SW-1:0] o_ss_ff, o_ss_in, o_as_ff, o_as_in;
   logic [2:0]    o_ty_ff, o_ty_in;
   logic          o_err_ff, o_err_in, o_trunc_ff, o_trunc_in, o_lastf_ff, o_lastf_in;

   // entry table
   logic                  ram_we;
   logic [SW-1:0]         ram_raddr;
   logic [SW-1:0]         rslot_ff, rslot_in;
   asc_pkg::entry_type    ld_entry, rd_entry;
   logic [EW-1:0]         ram_rdata;

   // bound cell row
   asc_pkg::cell_ctl_type  ctl;
   asc_pkg::cell_link_type links [NB];
   logic [NB-1:0]          eq_vec, tail_vec;
   logic                   dup;

   // load entry: saturate length, clear host bits, precompute last address
   logic [LW-1:0] ld_w, ld_len, ld_h;
   logic [AW-1:0] ld_addr, ld_mask, ld_net;
   always_comb begin
      ld_w    = (req_family == asc_pkg::FAM_V6) ? LW'(128) : LW'(32);
      ld_len  = (req_prefix_len > ld_w) ? ld_w : req_prefix_len;
      ld_h    = ld_w - ld_len;
      ld_mask = (AW'(1) << ld_h) - AW'(1);
      ld_addr = (req_family == asc_pkg::FAM_V6) ? {req_first_hi, req_first_lo}
                                                : {96'd0, req_first_lo[31:0]};
      ld_net  = ld_addr & ~ld_mask;
      ld_entry = '{family: req_family, special: req_special_purpose, len: ld_len,
                   net: ld_net, last: ld_net | ld_mask};
      ram_we  = (state_ff == asc_pkg::ST_IDLE) && start && (req_action == asc_pkg::ACT_LOAD);
   end

   asc_ram #(.WIDTH(EW), .DEPTH(asc_pkg::TABLE_ENTRIES)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (req_slot),
      .wdata (ld_entry),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_entry = asc_pkg::entry_type'(ram_rdata);

   // sorted row of bound cells
   for (genvar k = 0; k < NB; k++) begin : g_cell
      asc_pkg::cell_link_type left_link;
      logic [AW-1:0]          right_val;
      if (k == 0) begin : g_first
         assign left_link = '{val: '0, valid: 1'b0, lt: 1'b0};
      end else begin : g_mid
         assign left_link = links[k-1];
      end
      if (k == NB - 1) begin : g_end
         assign right_val = '0;
      end else begin : g_inner
         assign right_val = links[k+1].val;
      end
      assign tail_vec[k] = (n_ff == BW'(k + 1));
      asc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .left      (left_link),
         .right_val (right_val),
         .is_tail   (tail_vec[k]),
         .link      (links[k]),
         .eq        (eq_vec[k])
      );
   end

   assign dup = |eq_vec;

   // query front end
   logic [AW-1:0] in_first, in_last;
   logic          in_err;
   always_comb begin
      in_first = {req_first_hi, req_first_lo};
      in_last  = {req_last_hi, req_last_lo};
      in_err   = ((req_family == asc_pkg::FAM_V4) &&
                  (req_first_hi != 64'd0 || req_last_hi != 64'd0 ||
                   req_first_lo[63:32] != 32'd0 || req_last_lo[63:32] != 32'd0))
                 || (in_last < in_first);
   end

   // per-entry tests on the read data
   logic [AW-1:0]  sh, g_last;
   logic           fam_hit, ovl_hit, bnd_need, cov_hit, g_match;
   logic [AW-1:0]  bnd_val;
   logic [2:0]     g_ty;
   always_comb begin
      sh       = links[0].val;
      fam_hit  = rv_ff && rev_ff && (rd_entry.family == qfam_ff);
      ovl_hit  = fam_hit && !(rd_entry.last < qf_ff) && !(ql_ff < rd_entry.net);
      bnd_need = rph_ff ? (rd_entry.last < ql_ff) : (qf_ff < rd_entry.net);
      bnd_val  = rph_ff ? (rd_entry.last + AW'(1)) : rd_entry.net;
      cov_hit  = fam_hit && !(sh < rd_entry.net) && !(rd_entry.last < sh);
      g_ty     = asc_pkg::addr_class(qfam_ff, sh);
      g_last   = ((seg_idx_ff + BW'(1)) < n_ff) ? (links[1].val - AW'(1)) : ql_ff;
      g_match  = p_valid_ff && p_sf_ff == b_sf_ff && p_ss_ff == b_ss_ff &&
                 p_af_ff == b_af_ff && p_as_ff == b_as_ff && p_ty_ff == g_ty;
   end

   // controller
   always_comb begin
      state_in    = state_ff;
      qf_in       = qf_ff;
      ql_in       = ql_ff;
      qfam_in     = qfam_ff;
      cnt_in      = cnt_ff;
      ev_in       = ev_ff;
      n_in        = n_ff;
      seg_idx_in  = seg_idx_ff;
      ns_in       = ns_ff;
      pass_in     = pass_ff;
      emit_tot_in = emit_tot_ff;
      emitted_in  = emitted_ff;
      trunc_in    = trunc_ff;
      b_sf_in     = b_sf_ff;
      b_ss_in     = b_ss_ff;
      b_slen_in   = b_slen_ff;
      b_af_in     = b_af_ff;
      b_as_in     = b_as_ff;
      b_alen_in   = b_alen_ff;
      p_valid_in  = p_valid_ff;
      p_first_in  = p_first_ff;
      p_last_in   = p_last_ff;
      p_sf_in     = p_sf_ff;
      p_ss_in     = p_ss_ff;
      p_af_in     = p_af_ff;
      p_as_in     = p_as_ff;
      p_ty_in     = p_ty_ff;
      o_valid_in  = 1'b0;
      o_first_in  = o_first_ff;
      o_last_in   = o_last_ff;
      o_sf_in     = o_sf_ff;
      o_ss_in     = o_ss_ff;
      o_af_in     = o_af_ff;
      o_as_in     = o_as_ff;
      o_ty_in     = o_ty_ff;
      o_err_in    = o_err_ff;
      o_trunc_in  = o_trunc_ff;
      o_lastf_in  = o_lastf_ff;
      ctl         = '{op: asc_pkg::CELL_HOLD, ins_val: bnd_val, head_val: links[0].val};
      ram_raddr   = cnt_ff[SW-1:0];
      rv_in       = 1'b0;

      case (state_ff)
         asc_pkg::ST_IDLE: begin
            if (start) begin
               if (req_action == asc_pkg::ACT_LOAD) begin
                  ev_in[req_slot] = 1'b1;
               end else begin
                  qf_in   = in_first;
                  ql_in   = in_last;
                  qfam_in = req_family;
                  ctl.op  = asc_pkg::CELL_CLEAR;
                  n_in    = '0;
                  state_in = in_err ? asc_pkg::ST_ERR : asc_pkg::ST_BINIT;
               end
            end
         end
         asc_pkg::ST_ERR: begin
            o_valid_in = 1'b1;
            o_first_in = '0;
            o_last_in  = '0;
            o_sf_in    = 1'b0;
            o_ss_in    = '0;
            o_af_in    = 1'b0;
            o_as_in    = '0;
            o_ty_in    = asc_pkg::ADDR_UNICAST;
            o_err_in   = 1'b1;
            o_trunc_in = 1'b0;
            o_lastf_in = 1'b1;
            state_in   = asc_pkg::ST_IDLE;
         end
         asc_pkg::ST_BINIT: begin
            ctl.op      = asc_pkg::CELL_INSERT;
            ctl.ins_val = qf_ff;
            n_in        = BW'(1);
            cnt_in      = '0;
            state_in    = asc_pkg::ST_BSCAN;
         end
         asc_pkg::ST_BSCAN: begin
            // each slot read twice: start bound, then bound after its last address
            ram_raddr = cnt_ff[SW:1];
            rv_in     = (cnt_ff < CW'(2 * asc_pkg::TABLE_ENTRIES));
            if (ovl_hit && bnd_need && !dup) begin
               ctl.op = asc_pkg::CELL_INSERT;
               n_in   = n_ff + BW'(1);
            end
            if (cnt_ff == CW'(2 * asc_pkg::TABLE_ENTRIES)) begin
               cnt_in     = '0;
               seg_idx_in = '0;
               pass_in    = 1'b0;
               p_valid_in = 1'b0;
               ns_in      = '0;
               b_sf_in    = 1'b0;
               b_ss_in    = '0;
               b_slen_in  = '0;
               b_af_in    = 1'b0;
               b_as_in    = '0;
               b_alen_in  = '0;
               state_in   = asc_pkg::ST_SSCAN;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         asc_pkg::ST_SSCAN: begin
            // longest covering entry of each kind, lower slot kept on ties
            rv_in = (cnt_ff < CW'(asc_pkg::TABLE_ENTRIES));
            if (cov_hit) begin
               if (rd_entry.special) begin
                  if (!b_sf_ff || rd_entry.len > b_slen_ff) begin
                     b_sf_in   = 1'b1;
                     b_ss_in   = rslot_ff;
                     b_slen_in = rd_entry.len;
                  end
               end else begin
                  if (!b_af_ff || rd_entry.len > b_alen_ff) begin
                     b_af_in   = 1'b1;
                     b_as_in   = rslot_ff;
                     b_alen_in = rd_entry.len;
                  end
               end
            end
            if (cnt_ff == CW'(asc_pkg::TABLE_ENTRIES)) begin
               state_in = asc_pkg::ST_SEND;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         asc_pkg::ST_SEND: begin
            // merge with the pending segment or close it
            if (g_match) begin
               p_last_in = g_last;
            end else begin
               p_valid_in = 1'b1;
               p_first_in = sh;
               p_last_in  = g_last;
               p_sf_in    = b_sf_ff;
               p_ss_in    = b_ss_ff;
               p_af_in    = b_af_ff;
               p_as_in    = b_as_ff;
               p_ty_in    = g_ty;
            end
            ctl.op     = asc_pkg::CELL_ROTATE;
            seg_idx_in = seg_idx_ff + BW'(1);
            cnt_in     = '0;
            b_sf_in    = 1'b0;
            b_ss_in    = '0;
            b_slen_in  = '0;
            b_af_in    = 1'b0;
            b_as_in    = '0;
            b_alen_in  = '0;
            state_in   = ((seg_idx_ff + BW'(1)) == n_ff) ? asc_pkg::ST_FLUSH
                                                          : asc_pkg::ST_SSCAN;
            if (p_valid_ff && !g_match) begin
               if (!pass_ff) begin
                  ns_in = ns_ff + BW'(1);
               end else begin
                  o_valid_in = 1'b1;
                  o_first_in = p_first_ff;
                  o_last_in  = p_last_ff;
                  o_sf_in    = p_sf_ff;
                  o_ss_in    = p_ss_ff;
                  o_af_in    = p_af_ff;
                  o_as_in    = p_as_ff;
                  o_ty_in    = p_ty_ff;
                  o_err_in   = 1'b0;
                  o_trunc_in = trunc_ff;
                  o_lastf_in = ((emitted_ff + GW'(1)) == emit_tot_ff);
                  emitted_in = emitted_ff + GW'(1);
                  if ((emitted_ff + GW'(1)) == emit_tot_ff) begin
                     state_in = asc_pkg::ST_IDLE;
                  end
               end
            end
         end
         asc_pkg::ST_FLUSH: begin
            if (!pass_ff) begin
               // counting pass done; row is back in order after n rotations
               ns_in       = ns_ff + BW'(1);
               trunc_in    = ((ns_ff + BW'(1)) > BW'(asc_pkg::MAX_SEGMENTS));
               emit_tot_in = trunc_in ? GW'(asc_pkg::MAX_SEGMENTS)
                                      : GW'(ns_ff + BW'(1));
               emitted_in  = '0;
               pass_in     = 1'b1;
               seg_idx_in  = '0;
               p_valid_in  = 1'b0;
               cnt_in      = '0;
               state_in    = asc_pkg::ST_SSCAN;
            end else begin
               o_valid_in = 1'b1;
               o_first_in = p_first_ff;
               o_last_in  = p_last_ff;
               o_sf_in    = p_sf_ff;
               o_ss_in    = p_ss_ff;
               o_af_in    = p_af_ff;
               o_as_in    = p_as_ff;
               o_ty_in    = p_ty_ff;
               o_err_in   = 1'b0;
               o_trunc_in = trunc_ff;
               o_lastf_in = 1'b1;
               emitted_in = emitted_ff + GW'(1);
               state_in   = asc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = asc_pkg::ST_IDLE;
         end
      endcase
   end

   // slot of the entry now on the read data
   assign rslot_in = ram_raddr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= asc_pkg::ST_IDLE;
         ev_ff      <= '0;
         rv_ff      <= 1'b0;
         o_valid_ff <= 1'b0;
         n_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         ev_ff      <= ev_in;
         rv_ff      <= rv_in;
         o_valid_ff <= o_valid_in;
         n_ff       <= n_in;
      end
      qf_ff       <= qf_in;
      ql_ff       <= ql_in;
      qfam_ff     <= qfam_in;
      cnt_ff      <= cnt_in;
      rph_ff      <= rph_in;
      rev_ff      <= rev_in;
      rslot_ff    <= rslot_in;
      seg_idx_ff  <= seg_idx_in;
      ns_ff       <= ns_in;
      pass_ff     <= pass_in;
      emit_tot_ff <= emit_tot_in;
      emitted_ff  <= emitted_in;
      trunc_ff    <= trunc_in;
      b_sf_ff     <= b_sf_in;
      b_ss_ff     <= b_ss_in;
      b_slen_ff   <= b_slen_in;
      b_af_ff     <= b_af_in;
      b_as_ff     <= b_as_in;
      b_alen_ff   <= b_alen_in;
      p_valid_ff  <= p_valid_in;
      p_first_ff  <= p_first_in;
      p_last_ff   <= p_last_in;
      p_sf_ff     <= p_sf_in;
      p_ss_ff     <= p_ss_in;
      p_af_ff     <= p_af_in;
      p_as_ff     <= p_as_in;
      p_ty_ff     <= p_ty_in;
      o_first_ff  <= o_first_in;
      o_last_ff   <= o_last_in;
      o_sf_ff     <= o_sf_in;
      o_ss_ff     <= o_ss_in;
      o_af_ff     <= o_af_in;
      o_as_ff     <= o_as_in;
      o_ty_ff     <= o_ty_in;
      o_err_ff    <= o_err_in;
      o_trunc_ff  <= o_trunc_in;
      o_lastf_ff  <= o_lastf_in;
   end

   // read pipeline side info
   assign rph_in = cnt_ff[0];
   assign rev_in = ev_ff[ram_raddr];

   assign busy              = (state_ff != asc_pkg::ST_IDLE);
   assign rsp_valid         = o_valid_ff;
   assign rsp_seg_first_hi  = o_first_ff[127:64];
   assign rsp_seg_first_lo  = o_first_ff[63:0];
   assign rsp_seg_last_hi   = o_last_ff[127:64];
   assign rsp_seg_last_lo   = o_last_ff[63:0];
   assign rsp_special_found = o_sf_ff;
   assign rsp_special_slot  = o_ss_ff;
   assign rsp_space_found   = o_af_ff;
   assign rsp_space_slot    = o_as_ff;
   assign rsp_addr_type     = o_ty_ff;
   assign rsp_error         = o_err_ff;
   assign rsp_truncated     = o_trunc_ff;
   assign rsp_last          = o_lastf_ff;

endmodule

// File: rtl/asc_checker.sv
module asc_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_error,
   input logic        rsp_last,
   input logic        rsp_special_found,
   input logic [4:0]  rsp_special_slot,
   input logic        rsp_space_found,
   input logic [4:0]  rsp_space_slot,
   input logic [63:0] rsp_seg_first_lo
);

   // an error result is the final transfer of its query, with the segment start cleared
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last && rsp_seg_first_lo == 64'd0)
      else $error("error result not final or not cleared");

   // slot fields are zero when nothing was found
   a_spec_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_special_found |-> rsp_special_slot == 5'd0)
      else $error("special slot set without a match");

   a_space_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_space_found |-> rsp_space_slot == 5'd0)
      else $error("space slot set without a match");

   // more segments follow, so the block must still be working
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("idle while more transfers are due");

endmodule

bind address_range_segment_classifier asc_checker u_asc_checker (.*);
